>>> rtl/core/grid_bfs_shortest_path_unit_macros.svh
// Assertion macros shared by the grid maze solver RTL.
`ifndef GRID_BFS_SHORTEST_PATH_UNIT_MACROS_SVH
`define GRID_BFS_SHORTEST_PATH_UNIT_MACROS_SVH
`ifndef SYNTH
`define GBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
`define GBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define GBSP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GBSP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/gbsp_pkg.sv
package gbsp_pkg;
  localparam int MAX_SIDE = 64;
  localparam int SIDE_W = 6;
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = 12;
  localparam int QUEUE_DEPTH = 4096;
  localparam int QPTR_W = 13;
  localparam int DIST_W = 12;
  localparam logic [DIST_W-1:0] UNREACHED = '1;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_SOLVE = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    KIND_OPEN   = 2'd0,
    KIND_WALL   = 2'd1,
    KIND_START  = 2'd2,
    KIND_FINISH = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_POP,
    ST_POP_WAIT,
    ST_CHECK,
    ST_NB_REQ,
    ST_NB_WAIT,
    ST_NB_EVAL,
    ST_TR_REQ,
    ST_TR_WAIT,
    ST_TR_EVAL,
    ST_RD_WAIT,
    ST_OUT
  } state_t;
endpackage

>>> rtl/core/grid_bfs_shortest_path_unit.sv
// Grid maze solver, one item at a time; in_tready stays low until the result transfer.
// Writes and no-ops load the result on acceptance; reads pass through ST_RD_WAIT first.
// Solve items: clear sweep over all cells, then POP, POP_WAIT, CHECK per dequeued cell, plus
// REQ, WAIT, EVAL per in-grid neighbor or trace probe, REQ alone off the grid; stores are 1W1R RAMs.
// Synchronous reset (rst_n low) clears control, start and solve result and sets grid_side to 64,
// then a clearing pass over the distance and mark stores runs before the first transfer.
`include "grid_bfs_shortest_path_unit_macros.svh"
module grid_bfs_shortest_path_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // func[1:0], row[7:2], col[13:8], kind[15:14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // found, path_length, on_path, cell_distance, cell_kind
);
  localparam int AW = gbsp_pkg::ADDR_W;
  localparam int DW = gbsp_pkg::DIST_W;
  localparam int SW = gbsp_pkg::SIDE_W;

  gbsp_pkg::state_t state_r, state_nxt;
  logic [6:0] side_cfg_r;
  logic [SW-1:0] srow_r, scol_r;
  logic found_r, found_nxt;
  logic [DW-1:0] len_r, len_nxt;
  logic [1:0] func_r, func_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [AW:0] clr_r, clr_nxt;
  logic [gbsp_pkg::QPTR_W-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [DW-1:0] cdist_r, cdist_nxt;
  logic [1:0] dir_r, dir_nxt;
  logic [AW-1:0] nb_r, nb_nxt;
  logic [31:0] odata_r, odata_nxt;

  logic k_we, d_we, m_we, q_we;
  logic [AW-1:0] k_wa, k_ra, d_wa, d_ra, m_wa, m_ra, q_wa, q_ra, q_wd;
  logic [1:0] k_wd, k_rd;
  logic [DW-1:0] d_wd, d_rd;
  logic m_wd, m_rd;
  logic [AW-1:0] q_rd;

  gbsp_ram #(.WIDTH(2), .DEPTH(gbsp_pkg::CELLS)) u_kind (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
  gbsp_ram #(.WIDTH(DW), .DEPTH(gbsp_pkg::CELLS)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  gbsp_ram #(.WIDTH(1), .DEPTH(gbsp_pkg::CELLS)) u_mark (
    .clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  gbsp_ram #(.WIDTH(AW), .DEPTH(gbsp_pkg::QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

  logic [6:0] side;
  always_comb begin
    side = side_cfg_r;
    if (side_cfg_r == 7'd0) begin
      side = 7'd1;
    end else if (side_cfg_r > 7'(gbsp_pkg::MAX_SIDE)) begin
      side = 7'(gbsp_pkg::MAX_SIDE);
    end
  end

  // Neighbor of cur_r in direction dir_r, with a grid bounds check.
  logic [6:0] cr, cc, nr, nc;
  logic nb_ok;
  always_comb begin
    cr = {1'b0, cur_r[AW-1:SW]};
    cc = {1'b0, cur_r[SW-1:0]};
    nr = cr;
    nc = cc;
    nb_ok = 1'b1;
    case (dir_r)
      2'd0: begin nb_ok = (cr != 7'd0); nr = cr - 7'd1; end
      2'd1: begin nc = cc + 7'd1; nb_ok = (nc < side); end
      2'd2: begin nr = cr + 7'd1; nb_ok = (nr < side); end
      default: begin nb_ok = (cc != 7'd0); nc = cc - 7'd1; end
    endcase
  end

  logic [1:0] i_func, i_kind;
  logic [SW-1:0] i_row, i_col;
  assign i_func = in_tdata[1:0];
  assign i_row  = in_tdata[7:2];
  assign i_col  = in_tdata[13:8];
  assign i_kind = in_tdata[15:14];
  assign in_tready = (state_r == gbsp_pkg::ST_IDLE);
  assign out_tvalid = (state_r == gbsp_pkg::ST_OUT);
  assign out_tdata = odata_r;

  logic in_fire;
  assign in_fire = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    found_nxt = found_r;
    len_nxt = len_r;
    func_nxt = func_r;
    addr_nxt = addr_r;
    kind_nxt = kind_r;
    clr_nxt = clr_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cur_nxt = cur_r;
    cdist_nxt = cdist_r;
    dir_nxt = dir_r;
    nb_nxt = nb_r;
    odata_nxt = odata_r;
    k_we = 1'b0; k_wa = addr_r; k_wd = kind_r; k_ra = addr_r;
    d_we = 1'b0; d_wa = addr_r; d_wd = gbsp_pkg::UNREACHED; d_ra = addr_r;
    m_we = 1'b0; m_wa = addr_r; m_wd = 1'b0; m_ra = addr_r;
    q_we = 1'b0; q_wa = tail_r[AW-1:0]; q_wd = nb_r; q_ra = head_r[AW-1:0];
    case (state_r)
      gbsp_pkg::ST_IDLE: begin
        if (in_fire) begin
          func_nxt = i_func;
          addr_nxt = {i_row, i_col};
          kind_nxt = i_kind;
          k_ra = {i_row, i_col};
          d_ra = {i_row, i_col};
          m_ra = {i_row, i_col};
          case (gbsp_pkg::func_t'(i_func))
            gbsp_pkg::FUNC_WRITE: begin
              k_we = 1'b1; k_wa = {i_row, i_col}; k_wd = i_kind;
              odata_nxt = {19'd0, len_r, found_r};
              state_nxt = gbsp_pkg::ST_OUT;
            end
            gbsp_pkg::FUNC_SOLVE: begin
              clr_nxt = '0;
              found_nxt = 1'b0;
              len_nxt = gbsp_pkg::UNREACHED;
              state_nxt = gbsp_pkg::ST_CLEAR;
            end
            gbsp_pkg::FUNC_READ: state_nxt = gbsp_pkg::ST_RD_WAIT;
            default: begin
              odata_nxt = {19'd0, len_r, found_r};
              state_nxt = gbsp_pkg::ST_OUT;
            end
          endcase
        end
      end
      gbsp_pkg::ST_RD_WAIT: begin
        odata_nxt = {4'd0, k_rd, d_rd, m_rd, len_r, found_r};
        state_nxt = gbsp_pkg::ST_OUT;
      end
      gbsp_pkg::ST_CLEAR: begin
        if (!clr_r[AW]) begin
          d_we = 1'b1; d_wa = clr_r[AW-1:0]; d_wd = gbsp_pkg::UNREACHED;
          m_we = 1'b1; m_wa = clr_r[AW-1:0]; m_wd = 1'b0;
          clr_nxt = clr_r + 1'b1;
        end else if (func_r != gbsp_pkg::FUNC_SOLVE) begin
          state_nxt = gbsp_pkg::ST_IDLE;
        end else begin
          head_nxt = '0;
          tail_nxt = '0;
          if ({1'b0, srow_r} >= side || {1'b0, scol_r} >= side) begin
            odata_nxt = {19'd0, len_r, 1'b0};
            state_nxt = gbsp_pkg::ST_OUT;
          end else begin
            d_we = 1'b1; d_wa = {srow_r, scol_r}; d_wd = '0;
            q_we = 1'b1; q_wa = '0; q_wd = {srow_r, scol_r};
            tail_nxt = 13'd1;
            state_nxt = gbsp_pkg::ST_POP;
          end
        end
      end
      gbsp_pkg::ST_POP: begin
        if (head_r < tail_r) begin
          head_nxt = head_r + 1'b1;
          state_nxt = gbsp_pkg::ST_POP_WAIT;
        end else begin
          odata_nxt = {19'd0, len_r, found_r};
          state_nxt = gbsp_pkg::ST_OUT;
        end
      end
      gbsp_pkg::ST_POP_WAIT: begin
        cur_nxt = q_rd;
        k_ra = q_rd; d_ra = q_rd;
        state_nxt = gbsp_pkg::ST_CHECK;
      end
      gbsp_pkg::ST_CHECK: begin
        cdist_nxt = d_rd;
        if (k_rd == gbsp_pkg::KIND_FINISH) begin
          found_nxt = 1'b1;
          len_nxt = d_rd;
          m_we = 1'b1; m_wa = cur_r; m_wd = 1'b1;
          if (d_rd == '0) begin
            odata_nxt = {19'd0, d_rd, 1'b1};
            state_nxt = gbsp_pkg::ST_OUT;
          end else begin
            dir_nxt = 2'd0;
            state_nxt = gbsp_pkg::ST_TR_REQ;
          end
        end else if ({1'b0, d_rd} + 13'd1 >= {1'b0, gbsp_pkg::UNREACHED}) begin
          state_nxt = gbsp_pkg::ST_POP;
        end else begin
          dir_nxt = 2'd0;
          state_nxt = gbsp_pkg::ST_NB_REQ;
        end
      end
      gbsp_pkg::ST_NB_REQ: begin
        nb_nxt = {nr[SW-1:0], nc[SW-1:0]};
        k_ra = {nr[SW-1:0], nc[SW-1:0]}; d_ra = {nr[SW-1:0], nc[SW-1:0]};
        if (nb_ok) begin
          state_nxt = gbsp_pkg::ST_NB_WAIT;
        end else if (dir_r == 2'd3) begin
          state_nxt = gbsp_pkg::ST_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      gbsp_pkg::ST_NB_WAIT: begin
        k_ra = nb_r; d_ra = nb_r;
        state_nxt = gbsp_pkg::ST_NB_EVAL;
      end
      gbsp_pkg::ST_NB_EVAL: begin
        if (k_rd != gbsp_pkg::KIND_WALL && d_rd > cdist_r + 12'd1) begin
          d_we = 1'b1; d_wa = nb_r; d_wd = cdist_r + 12'd1;
          if (tail_r < 13'(gbsp_pkg::QUEUE_DEPTH)) begin
            q_we = 1'b1;
            tail_nxt = tail_r + 1'b1;
          end
        end
        k_ra = nb_r; d_ra = nb_r;
        if (dir_r == 2'd3) begin
          state_nxt = gbsp_pkg::ST_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
          state_nxt = gbsp_pkg::ST_NB_REQ;
        end
      end
      gbsp_pkg::ST_TR_REQ: begin
        nb_nxt = {nr[SW-1:0], nc[SW-1:0]};
        d_ra = {nr[SW-1:0], nc[SW-1:0]};
        if (nb_ok) begin
          state_nxt = gbsp_pkg::ST_TR_WAIT;
        end else if (dir_r == 2'd3) begin
          odata_nxt = {19'd0, len_r, found_r};
          state_nxt = gbsp_pkg::ST_OUT;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      gbsp_pkg::ST_TR_WAIT: begin
        d_ra = nb_r;
        state_nxt = gbsp_pkg::ST_TR_EVAL;
      end
      gbsp_pkg::ST_TR_EVAL: begin
        if (d_rd == cdist_r - 12'd1) begin
          m_we = 1'b1; m_wa = nb_r; m_wd = 1'b1;
          cur_nxt = nb_r;
          cdist_nxt = d_rd;
          dir_nxt = 2'd0;
          if (d_rd == '0) begin
            odata_nxt = {19'd0, len_r, found_r};
            state_nxt = gbsp_pkg::ST_OUT;
          end else begin
            state_nxt = gbsp_pkg::ST_TR_REQ;
          end
        end else if (dir_r == 2'd3) begin
          odata_nxt = {19'd0, len_r, found_r};
          state_nxt = gbsp_pkg::ST_OUT;
        end else begin
          dir_nxt = dir_r + 2'd1;
          state_nxt = gbsp_pkg::ST_TR_REQ;
        end
      end
      gbsp_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = gbsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gbsp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbsp_pkg::ST_CLEAR;
      clr_r <= '0;
      func_r <= gbsp_pkg::FUNC_NOP;
      side_cfg_r <= 7'd64;
      srow_r <= '0;
      scol_r <= '0;
      found_r <= 1'b0;
      len_r <= gbsp_pkg::UNREACHED;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      func_r <= func_nxt;
      found_r <= found_nxt;
      len_r <= len_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      if (cfg_we) begin
        side_cfg_r <= cfg_wdata;
      end
      if (in_fire && i_func == gbsp_pkg::FUNC_WRITE) begin
        if (i_kind == gbsp_pkg::KIND_START) begin
          srow_r <= i_row; scol_r <= i_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    kind_r <= kind_nxt;
    cur_r <= cur_nxt;
    cdist_r <= cdist_nxt;
    dir_r <= dir_nxt;
    nb_r <= nb_nxt;
    odata_r <= odata_nxt;
  end

  `GBSP_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, !out_tvalid)
  `GBSP_ASSERT_IMPL(a_head_le_tail, clk, rst_n, 1'b1, head_r <= tail_r)
  `GBSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `GBSP_ASSERT_IMPL(a_tail_cap, clk, rst_n, 1'b1, tail_r <= 13'(gbsp_pkg::QUEUE_DEPTH))
endmodule

>>> rtl/core/gbsp_ram.sv
module gbsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> tb/tb_grid_bfs_shortest_path_checker.sv
`timescale 1ns / 1ps
module tb_grid_bfs_shortest_path_checker
  import gbsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [3:0]  pad;
    logic [1:0]  cell_kind;
    logic [11:0] cell_distance;
    logic        on_path;
    logic [11:0] path_length;
    logic        found;
  } maze_result_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic [1:0] func;
  } maze_cmd_t;

  logic [1:0]  kind_mem [CELLS];
  logic [11:0] dist_mem [CELLS];
  bit          mark_mem [CELLS];
  logic [6:0]  side_reg;
  int          start_r, start_c;
  bit          last_found;
  logic [11:0] last_length;
  maze_result_t expected_results[$];

  assign pending = expected_results.size();

  function automatic int side_now();
    if (side_reg == 0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  function automatic void run_solve();
    int s, cur, nd, r, c, nr, nc, n, want, i;
    int visit_q[$];
    bit hit, moved;
    int dr[4] = '{-1, 0, 1, 0};
    int dc[4] = '{0, 1, 0, -1};
    s = side_now();
    hit = 0;
    cur = 0;
    for (i = 0; i < CELLS; i++) begin
      dist_mem[i] = UNREACHED;
      mark_mem[i] = 0;
    end
    last_found = 0;
    last_length = UNREACHED;
    if (start_r >= s || start_c >= s) return;
    cur = start_r * MAX_SIDE + start_c;
    dist_mem[cur] = 0;
    visit_q.push_back(cur);
    while (visit_q.size() > 0) begin
      cur = visit_q.pop_front();
      if (kind_mem[cur] == KIND_FINISH) begin
        hit = 1;
        break;
      end
      nd = dist_mem[cur] + 1;
      if (nd >= int'(UNREACHED)) continue;
      r = cur / MAX_SIDE;
      c = cur % MAX_SIDE;
      for (i = 0; i < 4; i++) begin
        nr = r + dr[i];
        nc = c + dc[i];
        if (nr < 0 || nc < 0 || nr >= s || nc >= s) continue;
        n = nr * MAX_SIDE + nc;
        if (kind_mem[n] != KIND_WALL && int'(dist_mem[n]) > nd) begin
          dist_mem[n] = nd;
          visit_q.push_back(n);
        end
      end
    end
    if (!hit) return;
    last_found = 1;
    last_length = dist_mem[cur];
    mark_mem[cur] = 1;
    while (dist_mem[cur] != 0) begin
      want = dist_mem[cur] - 1;
      r = cur / MAX_SIDE;
      c = cur % MAX_SIDE;
      moved = 0;
      for (i = 0; i < 4; i++) begin
        nr = r + dr[i];
        nc = c + dc[i];
        if (nr < 0 || nc < 0 || nr >= s || nc >= s) continue;
        n = nr * MAX_SIDE + nc;
        if (int'(dist_mem[n]) == want) begin
          cur = n;
          moved = 1;
          break;
        end
      end
      if (!moved) break;
      mark_mem[cur] = 1;
    end
  endfunction

  function automatic maze_result_t predict_result(maze_cmd_t cmd);
    maze_result_t res;
    int idx;
    res = '0;
    idx = cmd.row * MAX_SIDE + cmd.col;
    case (func_t'(cmd.func))
      FUNC_WRITE: begin
        kind_mem[idx] = cmd.kind;
        if (cmd.kind == KIND_START) begin
          start_r = cmd.row;
          start_c = cmd.col;
        end
      end
      FUNC_SOLVE: run_solve();
      FUNC_READ: begin
        res.on_path = mark_mem[idx];
        res.cell_distance = dist_mem[idx];
        res.cell_kind = kind_mem[idx];
      end
      default: ;
    endcase
    res.found = last_found;
    res.path_length = last_length;
    return res;
  endfunction

  always @(posedge clk) begin
    maze_result_t got, want;
    if (!rst_n) begin
      side_reg <= 7'd64;
      start_r = 0;
      start_c = 0;
      last_found = 0;
      last_length = UNREACHED;
      for (int i = 0; i < CELLS; i++) begin
        kind_mem[i] = KIND_OPEN;
        dist_mem[i] = UNREACHED;
        mark_mem[i] = 0;
      end
      expected_results.delete();
      errors <= 0;
    end else begin
      if (cfg_we) side_reg <= cfg_wdata;
      if (in_tvalid && in_tready) expected_results.push_back(predict_result(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_results.size() == 0) begin
          $display("%t: unexpected result transfer, expected none, actual %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.found !== want.found || got.path_length !== want.path_length ||
              got.on_path !== want.on_path || got.cell_distance !== want.cell_distance ||
              got.cell_kind !== want.cell_kind || got.pad !== want.pad) begin
            $display("%t: mismatch expected found=%0d len=%0d mark=%0d dist=%0d kind=%0d",
                     $time, want.found, want.path_length, want.on_path,
                     want.cell_distance, want.cell_kind);
            $display("%t:          actual   found=%0d len=%0d mark=%0d dist=%0d kind=%0d",
                     $time, got.found, got.path_length, got.on_path,
                     got.cell_distance, got.cell_kind);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_grid_bfs_shortest_path_unit.sv
`timescale 1ns / 1ps
module tb_grid_bfs_shortest_path_unit;
  import gbsp_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  int          errors, pending;
  int          cycles = 0;
  int          sent = 0;
  bit          quiet = 0;
  int          stall_left = 0;

  grid_bfs_shortest_path_unit u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  tb_grid_bfs_shortest_path_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_tready <= 1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_tready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1;
    end
  end

  task automatic send(func_t f, int r, int c, kind_t k);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {k, 6'(c), 6'(r), f};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic set_side(int s);
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= 7'(s);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_maze(int s);
    int r, c;
    for (r = 0; r < s; r++)
      for (c = 0; c < s; c++)
        send(FUNC_WRITE, r, c, ($urandom_range(0, 9) < 3) ? KIND_WALL : KIND_OPEN);
    send(FUNC_WRITE, $urandom_range(0, s - 1), $urandom_range(0, s - 1), KIND_START);
    repeat ($urandom_range(1, 2))
      send(FUNC_WRITE, $urandom_range(0, s - 1), $urandom_range(0, s - 1), KIND_FINISH);
  endtask

  initial begin
    int s, i, r, c, sides[$];
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    for (r = 0; r < 5; r++)
      for (c = 0; c < 5; c++)
        send(FUNC_WRITE, r, c,
             kind_t'((r == 4 || c == 4 || $urandom_range(0, 9) < 2) ? KIND_WALL : KIND_OPEN));
    send(FUNC_READ, 0, 0, KIND_OPEN);
    send(FUNC_WRITE, 0, 0, KIND_OPEN);
    send(FUNC_WRITE, 3, 3, KIND_FINISH);
    send(FUNC_SOLVE, 0, 0, KIND_OPEN);
    send(FUNC_READ, 0, 0, KIND_OPEN);
    send(FUNC_READ, 3, 3, KIND_OPEN);
    send(FUNC_READ, 2, 1, KIND_OPEN);
    send(FUNC_NOP, 63, 63, KIND_FINISH);

    set_side(0);
    send(FUNC_WRITE, 0, 0, KIND_FINISH);
    send(FUNC_SOLVE, 0, 0, KIND_OPEN);
    send(FUNC_READ, 0, 0, KIND_OPEN);
    send(FUNC_WRITE, 5, 5, KIND_START);
    send(FUNC_SOLVE, 0, 0, KIND_OPEN);
    send(FUNC_READ, 5, 5, KIND_OPEN);

    set_side(127);
    send(FUNC_WRITE, 0, 63, KIND_START);
    send(FUNC_WRITE, 1, 63, KIND_FINISH);
    send(FUNC_WRITE, 0, 62, KIND_FINISH);
    send(FUNC_SOLVE, 0, 0, KIND_OPEN);
    send(FUNC_READ, 0, 63, KIND_OPEN);
    send(FUNC_READ, 1, 63, KIND_OPEN);
    send(FUNC_READ, 0, 62, KIND_OPEN);

    set_side(3);
    send(FUNC_WRITE, 1, 1, KIND_START);
    send(FUNC_WRITE, 0, 1, KIND_WALL);
    send(FUNC_WRITE, 1, 0, KIND_WALL);
    send(FUNC_WRITE, 1, 2, KIND_WALL);
    send(FUNC_WRITE, 2, 1, KIND_WALL);
    send(FUNC_WRITE, 2, 2, KIND_FINISH);
    send(FUNC_SOLVE, 0, 0, KIND_OPEN);
    send(FUNC_READ, 2, 2, KIND_OPEN);

    sides = '{1, 2, 4, 6, 8, 12, 7, 10, 5, 9, 3, 11};
    i = 0;
    while (sent < 1350) begin
      s = sides[i % sides.size()];
      if (sent > 1150) quiet = 1;
      set_side(s);
      repeat (2) begin
        random_maze(s);
        send(FUNC_SOLVE, $urandom_range(0, 63), $urandom_range(0, 63), KIND_OPEN);
        repeat ($urandom_range(6, 14))
          send(FUNC_READ, $urandom_range(0, s - 1), $urandom_range(0, s - 1),
               kind_t'($urandom_range(0, 3)));
        repeat ($urandom_range(2, 6)) begin
          r = $urandom_range(0, 63);
          c = $urandom_range(0, 63);
          case ($urandom_range(0, 3))
            0: send(FUNC_NOP, r, c, kind_t'($urandom_range(0, 3)));
            1: send(FUNC_READ, r % s, c % s, kind_t'($urandom_range(0, 3)));
            2: send(FUNC_WRITE, r, c, (r < s && c < s) ? KIND_OPEN : KIND_WALL);
            default: send(FUNC_SOLVE, r, c, kind_t'($urandom_range(0, 3)));
          endcase
        end
        if ($urandom_range(0, 2) == 0) begin
          send(FUNC_WRITE, s - 1, s - 1, KIND_START);
          send(FUNC_SOLVE, 0, 0, KIND_OPEN);
          send(FUNC_READ, s - 1, s - 1, KIND_OPEN);
        end
      end
      i++;
    end

    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> grid_bfs_shortest_path_unit.f
+incdir+rtl/core
rtl/core/gbsp_pkg.sv
rtl/core/gbsp_ram.sv
rtl/core/grid_bfs_shortest_path_unit.sv
tb/tb_grid_bfs_shortest_path_checker.sv
tb/tb_grid_bfs_shortest_path_unit.sv
